// ===== rtl/core/sclal_pkg.sv =====
// ----------------------------------------------------------------------------
// sclal_pkg
// Shared widths, codes and defaults of the set-colored line allocator.
// ----------------------------------------------------------------------------
package sclal_pkg;

   // payload field widths
   localparam int LINE_IDX_W  = 12;
   localparam int SETS_W      = 13;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   // defaults for the top-level parameters
   localparam int DEF_NUM_LINES = 4096;
   localparam int DEF_MAX_COUNT = 64;

   // register reset values
   localparam logic [SETS_W-1:0] L1_SETS_RESET = SETS_W'(64);
   localparam logic [SETS_W-1:0] L2_SETS_RESET = SETS_W'(1024);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_L1_SETS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_L2_SETS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUGE_PAGES = 2'd2;

   // operation and level codes
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RETURN  = 1'b1;
   localparam logic LEVEL_L1   = 1'b0;
   localparam logic LEVEL_L2   = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd2;

endpackage

// ===== rtl/core/sclal_if.sv =====
// ----------------------------------------------------------------------------
// sclal_if
// Valid/ready channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface sclal_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic                               level;
   logic [sclal_pkg::LINE_IDX_W-1:0]   set_index;
   logic [sclal_pkg::COUNT_W-1:0]      count;
   logic [sclal_pkg::LINE_IDX_W-1:0]   line_index;

   modport source (output valid, operation, level, set_index, count, line_index,
                   input ready);
   modport sink   (input valid, operation, level, set_index, count, line_index,
                   output ready);
endinterface

interface sclal_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sclal_pkg::LINE_IDX_W-1:0]   granted_line;
   logic [sclal_pkg::STATUS_W-1:0]     status;
   logic                               last;

   modport source (output valid, granted_line, status, last, input ready);
   modport sink   (input valid, granted_line, status, last, output ready);
endinterface

interface sclal_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sclal_pkg::CSR_INDEX_W-1:0]  index;
   logic [sclal_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sclal_ram.sv =====
// ----------------------------------------------------------------------------
// sclal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sclal_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/set_colored_line_allocator_core.sv =====
// ----------------------------------------------------------------------------
// set_colored_line_allocator_core
// Hands out cache lines of one set color from an allocation bitmap.
// ----------------------------------------------------------------------------
//
//  channel   | dir | transaction
//  ----------+-----+-----------------------------------------------------------
//  req_bus   | in  | request lines (level, set_index, count) or return a line
//  rsp_bus   | out | one granted line, or an exhausted / unsupported status
//  csr_bus   | in  | register write: l1_sets, l2_sets, huge_pages
//
//  A return writes the bitmap as it is accepted. A request reads the map,
//  then tests and sets, for each candidate line, and passes each granted
//  line through a push step; the bitmap's single read port sets this pace.
//  Reset starts a clearing pass through every line of the bitmap; no
//  request or return is taken meanwhile, register writes always are.
//  A stalled response holds the scan at the next grant; the output register
//  lets the final response wait while the next transaction is taken.
//
module set_colored_line_allocator_core #(
   parameter int NUM_LINES = sclal_pkg::DEF_NUM_LINES,
   parameter int MAX_COUNT = sclal_pkg::DEF_MAX_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   sclal_req_if.sink   req_bus,
   sclal_rsp_if.source rsp_bus,
   sclal_csr_if.sink   csr_bus
);

   import sclal_pkg::*;

   localparam int LINE_W = $clog2(NUM_LINES);
   // scan pointer must hold the last line plus the widest stride
   localparam int SCAN_W = ((LINE_W > SETS_W) ? LINE_W : SETS_W) + 1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,   // bitmap clearing pass after reset
      ST_IDLE  = 5'b00010,   // ready for a transaction
      ST_READ  = 5'b00100,   // bounds check, issue bitmap read
      ST_TEST  = 5'b01000,   // test bit, set on a free line
      ST_PUSH  = 5'b10000    // hand staged result to the output register
   } state_type;

   state_type              state_ff, state_in;

   // configuration
   logic [SETS_W-1:0]      l1_sets_ff, l1_sets_in;
   logic [SETS_W-1:0]      l2_sets_ff, l2_sets_in;
   logic                   huge_ff, huge_in;

   // sequencer state
   logic [LINE_W-1:0]      clr_ff, clr_in;
   logic [SCAN_W-1:0]      line_ff, line_in;
   logic [SETS_W-1:0]      stride_ff, stride_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     granted_ff, granted_in;

   // staged result
   logic [LINE_IDX_W-1:0]  res_line_ff, res_line_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   res_last_ff, res_last_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LINE_IDX_W-1:0]  rsp_line_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_last_ff;

   // bitmap port
   logic                   map_wr_en;
   logic [LINE_W-1:0]      map_wr_addr;
   logic                   map_wr_data;
   logic                   map_rd_en;
   logic                   map_rd_data;

   logic                   req_fire;
   logic                   slot_free;
   logic                   rsp_load;
   logic [SCAN_W-1:0]      line_next;      // shared stride adder
   logic                   line_in_range;  // scan bound compare
   logic [SCAN_W-1:0]      ret_line;
   logic [COUNT_W-1:0]     count_sat;
   logic [SETS_W-1:0]      stride_sel;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load      = (state_ff == ST_PUSH) && slot_free;

   assign line_next     = line_ff + SCAN_W'(stride_ff);
   assign line_in_range = line_ff < SCAN_W'(NUM_LINES);
   assign ret_line      = SCAN_W'(req_bus.line_index);

   assign count_sat  = (req_bus.count > COUNT_W'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT)
                                                             : req_bus.count;
   assign stride_sel = (req_bus.level == LEVEL_L2) ? l2_sets_ff : l1_sets_ff;

   // register writes
   always_comb begin
      l1_sets_in = l1_sets_ff;
      l2_sets_in = l2_sets_ff;
      huge_in    = huge_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_L1_SETS:    l1_sets_in = csr_bus.data;
            CSR_L2_SETS:    l2_sets_in = csr_bus.data;
            CSR_HUGE_PAGES: huge_in    = csr_bus.data[0];
            default:        ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      line_in       = line_ff;
      stride_in     = stride_ff;
      count_in      = count_ff;
      granted_in    = granted_ff;
      res_line_in   = res_line_ff;
      res_status_in = res_status_ff;
      res_last_in   = res_last_ff;
      map_wr_en     = 1'b0;
      map_wr_addr   = line_ff[LINE_W-1:0];
      map_wr_data   = 1'b0;
      map_rd_en     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_ff;
            clr_in      = clr_ff + LINE_W'(1);
            if (clr_ff == LINE_W'(NUM_LINES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == OP_RETURN) begin
                  // out-of-range returns are dropped
                  map_wr_en   = ret_line < SCAN_W'(NUM_LINES);
                  map_wr_addr = ret_line[LINE_W-1:0];
               end else if (req_bus.level == LEVEL_L2 && !huge_ff) begin
                  res_line_in   = '0;
                  res_status_in = STATUS_UNSUPPORTED;
                  res_last_in   = 1'b1;
                  state_in      = ST_PUSH;
               end else if (count_sat != '0) begin
                  line_in    = SCAN_W'(req_bus.set_index);
                  stride_in  = (stride_sel == '0) ? SETS_W'(1) : stride_sel;
                  count_in   = count_sat;
                  granted_in = '0;
                  state_in   = ST_READ;
               end
            end
         end

         ST_READ: begin
            if (line_in_range) begin
               map_rd_en = 1'b1;
               state_in  = ST_TEST;
            end else begin
               res_line_in   = '0;
               res_status_in = STATUS_EXHAUSTED;
               res_last_in   = 1'b1;
               state_in      = ST_PUSH;
            end
         end

         ST_TEST: begin
            if (!map_rd_data) begin
               map_wr_en     = 1'b1;
               map_wr_data   = 1'b1;
               granted_in    = granted_ff + COUNT_W'(1);
               res_line_in   = line_ff[LINE_IDX_W-1:0];
               res_status_in = STATUS_OK;
               res_last_in   = (granted_ff + COUNT_W'(1)) == count_ff;
               state_in      = ST_PUSH;
            end else begin
               line_in  = line_next;
               state_in = ST_READ;
            end
         end

         ST_PUSH: begin
            if (slot_free) begin
               if (res_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  line_in  = line_next;
                  state_in = ST_READ;
               end
            end
         end

         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         l1_sets_ff   <= L1_SETS_RESET;
         l2_sets_ff   <= L2_SETS_RESET;
         huge_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         l1_sets_ff   <= l1_sets_in;
         l2_sets_ff   <= l2_sets_in;
         huge_ff      <= huge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      line_ff       <= line_in;
      stride_ff     <= stride_in;
      count_ff      <= count_in;
      granted_ff    <= granted_in;
      res_line_ff   <= res_line_in;
      res_status_ff <= res_status_in;
      res_last_ff   <= res_last_in;
      if (rsp_load) begin
         rsp_line_ff   <= res_line_ff;
         rsp_status_ff <= res_status_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.granted_line = rsp_line_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // allocation bitmap, one bit per line
   sclal_ram #(
      .WIDTH (1),
      .DEPTH (NUM_LINES)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (line_ff[LINE_W-1:0]),
      .rd_data (map_rd_data)
   );

endmodule

// ===== rtl/core/sclal_checker.sv =====
// ----------------------------------------------------------------------------
// sclal_checker
// Port-level assertions for the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module sclal_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_operation,
   input logic [sclal_pkg::COUNT_W-1:0]   req_count,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [sclal_pkg::LINE_IDX_W-1:0] rsp_granted_line,
   input logic [sclal_pkg::STATUS_W-1:0]  rsp_status,
   input logic                            rsp_last
);

   import sclal_pkg::*;

   // response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // clearing pass keeps input closed right after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("input ready during clearing pass");

   // a non-empty request occupies the sequencer
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_REQUEST && req_count != '0
      |=> !req_ready)
      else $error("ready while a request is in progress");

   // a return completes without holding the input
   a_return_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_RETURN |=> req_ready)
      else $error("return held the input");

   // error results carry no line and end the transaction
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last && rsp_granted_line == '0)
      else $error("error result not final or carries a line");

endmodule

bind set_colored_line_allocator_core sclal_checker u_sclal_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_operation    (req_bus.operation),
   .req_count        (req_bus.count),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_granted_line (rsp_bus.granted_line),
   .rsp_status       (rsp_bus.status),
   .rsp_last         (rsp_bus.last)
);

// ===== tb/sv/sclal_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sclal_tb_pkg
// Transaction types and grant scoreboard for the line allocator testbench.
// ----------------------------------------------------------------------------
package sclal_tb_pkg;
   import sclal_pkg::*;

   localparam int NUM_LINES  = DEF_NUM_LINES;
   localparam int MAX_COUNT  = DEF_MAX_COUNT;
   localparam int PRINT_CAP  = 30;

   typedef struct packed {
      logic                  operation;
      logic                  level;
      logic [LINE_IDX_W-1:0] set_index;
      logic [COUNT_W-1:0]    count;
      logic [LINE_IDX_W-1:0] line_index;
   } alloc_req_type;

   typedef struct packed {
      logic [LINE_IDX_W-1:0] line;
      logic [STATUS_W-1:0]   status;
      logic                  last;
   } grant_type;

   class grant_scoreboard;
      bit                line_taken [NUM_LINES];
      bit [SETS_W-1:0]   l1_step;
      bit [SETS_W-1:0]   l2_step;
      bit                huge_ok;
      bit [LINE_IDX_W-1:0] recent_grant;
      grant_type         expected_grants [$];
      int                errors;
      int                checked;
      int                requests;
      int                returns;
      int                grants;
      int                exhausted;
      int                unsupported;
      int                writes;

      function new();
         l1_step = L1_SETS_RESET;
         l2_step = L2_SETS_RESET;
         huge_ok   = 1'b0;
         recent_grant = '0;
         foreach (line_taken[i]) line_taken[i] = 1'b0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         writes++;
         case (idx)
            CSR_L1_SETS:    l1_step = value;
            CSR_L2_SETS:    l2_step = value;
            CSR_HUGE_PAGES: huge_ok = value[0];
            default: ;
         endcase
      endfunction

      // any allocated line, scanning from a random start; -1 when none
      function int pick_taken();
         int start;
         start = $urandom_range(0, NUM_LINES - 1);
         for (int k = 0; k < NUM_LINES; k++)
            if (line_taken[(start + k) % NUM_LINES]) return (start + k) % NUM_LINES;
         return -1;
      endfunction

      function void push_grant(int line, logic [STATUS_W-1:0] st, logic fin);
         grant_type g;
         g.line   = LINE_IDX_W'(line);
         g.status = st;
         g.last   = fin;
         expected_grants.push_back(g);
      endfunction

      // accepted request transaction: update the map, queue what it yields
      function void predict_grants(alloc_req_type it);
         int stride;
         int want;
         int got;
         if (it.operation == OP_RETURN) begin
            returns++;
            if (it.line_index < NUM_LINES) line_taken[it.line_index] = 1'b0;
            return;
         end
         requests++;
         if (it.level == LEVEL_L2 && !huge_ok) begin
            unsupported++;
            push_grant(0, STATUS_UNSUPPORTED, 1'b1);
            return;
         end
         want = (it.count > MAX_COUNT) ? MAX_COUNT : int'(it.count);
         if (want == 0) return;
         stride = (it.level == LEVEL_L1) ? int'(l1_step) : int'(l2_step);
         if (stride == 0) stride = 1;
         got = 0;
         for (int line = int'(it.set_index); line < NUM_LINES; line += stride) begin
            if (!line_taken[line]) begin
               line_taken[line] = 1'b1;
               recent_grant = LINE_IDX_W'(line);
               got++;
               grants++;
               push_grant(line, STATUS_OK, got == want);
               if (got == want) return;
            end
         end
         exhausted++;
         push_grant(0, STATUS_EXHAUSTED, 1'b1);
      endfunction

      task match_result(grant_type got);
         grant_type want;
         checked++;
         if (expected_grants.size() == 0) begin
            report($sformatf("unexpected result line %0d status %0d last %0d",
                             got.line, got.status, got.last));
            return;
         end
         want = expected_grants.pop_front();
         if (got.line !== want.line)
            report($sformatf("result %0d: granted_line %0d, want %0d",
                             checked, got.line, want.line));
         if (got.status !== want.status)
            report($sformatf("result %0d: status %0d, want %0d",
                             checked, got.status, want.status));
         if (got.last !== want.last)
            report($sformatf("result %0d: last %0d, want %0d", checked, got.last, want.last));
      endtask

      task flush_missing();
         grant_type want;
         while (expected_grants.size() != 0) begin
            want = expected_grants.pop_front();
            report($sformatf("missing result line %0d status %0d last %0d",
                             want.line, want.status, want.last));
         end
      endtask
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-colored line allocator: directed corner
// cases, then randomized request/return traffic under several stride and
// huge-page settings, with random gaps on both channels and a long output
// stall, checked against an in-bench model of the allocation map.
// ----------------------------------------------------------------------------
module tb_top;
   import sclal_pkg::*;
   import sclal_tb_pkg::*;

   localparam int     CLK_HALF      = 6;
   localparam int     RESET_CYCLES  = 10;
   localparam int     SETTLE_CYCLES = 32;     // returns finish without a response; slack
   localparam int     GAP_MAX       = 12;
   localparam int     HOLD_CYCLES   = 400;    // long output stall for back-pressure
   localparam int     DRAIN_LIMIT   = 50_000; // one full-map scan plus stalls
   localparam int     PHASE_ITEMS   = 30;
   localparam longint LIMIT_CYCLES  = 10_000_000;

   logic clock = 1'b0;
   logic reset;

   sclal_req_if req_bus ();
   sclal_rsp_if rsp_bus ();
   sclal_csr_if csr_bus ();

   grant_scoreboard sb = new();

   // pacing knobs; rsp side ones change via NBA so the sink sees them cleanly
   bit   req_calm     = 1'b0;
   logic rsp_calm     = 1'b0;
   logic hold_results = 1'b0;
   logic pressure_go  = 1'b0;

   // small pool of set indexes so colors fill up and exhaust
   logic [LINE_IDX_W-1:0] color_pool [4];

   set_colored_line_allocator_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #(CLK_HALF) clock = ~clock;

   // ------------------------------------------------------------------------
   // Hard stop: far beyond the slowest legal run (every request scanning the
   // whole map at stride 1 while every result waits out a full stall).
   // ------------------------------------------------------------------------
   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("** set_colored_line_allocator_core: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response sink: samples at the rising edge, checks every accepted
   // transaction, then draws a fresh stall for the next one.
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int        stall_left;
      grant_type got;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.line   = rsp_bus.granted_line;
            got.status = rsp_bus.status;
            got.last   = rsp_bus.last;
            sb.match_result(got);
            stall_left = rsp_calm ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (reset || hold_results || stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            if (stall_left > 0) stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Long hold on the result side, counted here, while requests keep coming.
   initial begin : result_hold
      wait (pressure_go === 1'b1);
      hold_results <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_results <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Request side. valid is left high after acceptance; the next call either
   // keeps it high (no gap) or drops it for the drawn gap, so each step sees
   // at most one assignment to it.
   // ------------------------------------------------------------------------
   task automatic send_item(input alloc_req_type it);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= it.operation;
      req_bus.level      <= it.level;
      req_bus.set_index  <= it.set_index;
      req_bus.count      <= it.count;
      req_bus.line_index <= it.line_index;
      do @(posedge clock); while (!req_bus.ready);
      sb.predict_grants(it);
   endtask

   // lower valid, wait for every expected result, then let the core settle
   task automatic drain(input int limit);
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (sb.expected_grants.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register writes only while the core is idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, value);
   endtask

   task automatic set_regs(input int l1, input int l2, input bit huge);
      write_reg(CSR_L1_SETS, CSR_DATA_W'(l1));
      write_reg(CSR_L2_SETS, CSR_DATA_W'(l2));
      write_reg(CSR_HUGE_PAGES, CSR_DATA_W'(huge));
      csr_bus.valid <= 1'b0;
   endtask

   // unused fields get random values: the core must ignore them
   function automatic alloc_req_type mk_request(input logic lvl, input int set,
                                                input int cnt);
      alloc_req_type it;
      it.operation  = OP_REQUEST;
      it.level      = lvl;
      it.set_index  = LINE_IDX_W'(set);
      it.count      = COUNT_W'(cnt);
      it.line_index = LINE_IDX_W'($urandom);
      return it;
   endfunction

   function automatic alloc_req_type mk_return(input int line);
      alloc_req_type it;
      it.operation  = OP_RETURN;
      it.level      = 1'($urandom);
      it.set_index  = LINE_IDX_W'($urandom);
      it.count      = COUNT_W'($urandom);
      it.line_index = LINE_IDX_W'(line);
      return it;
   endfunction

   // mostly requests on the color pool with small counts; some saturating
   // and zero counts, some L2, and returns of held or arbitrary lines
   function automatic alloc_req_type random_item();
      int roll;
      int held;
      int set;
      int cnt;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         held = sb.pick_taken();
         if (held >= 0 && $urandom_range(0, 3) != 0) return mk_return(held);
         return mk_return($urandom_range(0, NUM_LINES - 1));
      end
      set = ($urandom_range(0, 9) < 7) ? int'(color_pool[$urandom_range(0, 3)])
                                       : $urandom_range(0, NUM_LINES - 1);
      case ($urandom_range(0, 9))
         0:       cnt = 0;
         1:       cnt = $urandom_range(MAX_COUNT, 127);
         2, 3:    cnt = $urandom_range(9, MAX_COUNT - 1);
         default: cnt = $urandom_range(1, 8);
      endcase
      return mk_request((roll < 45) ? LEVEL_L2 : LEVEL_L1, set, cnt);
   endfunction

   task automatic run_random(input int n, input bit pressure);
      foreach (color_pool[i]) color_pool[i] = LINE_IDX_W'($urandom);
      req_calm = pressure;
      if (pressure) pressure_go <= 1'b1;
      for (int k = 0; k < n; k++) begin
         if (!pressure && $urandom_range(0, 9) == 0) req_calm = !req_calm;
         if ($urandom_range(0, 11) == 0) rsp_calm <= !rsp_calm;
         send_item(random_item());
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_REQUEST;
      req_bus.level      <= LEVEL_L1;
      req_bus.set_index  <= '0;
      req_bus.count      <= '0;
      req_bus.line_index <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_L1_SETS;
      csr_bus.data       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings (stride 64 for L1, L2 disabled). The first request
      // also waits out the bitmap clearing pass through its handshake.
      send_item(mk_request(LEVEL_L2, 5, 3));        // L2 without huge pages
      send_item(mk_request(LEVEL_L1, 0, 1));        // single grant, line 0
      send_item(mk_request(LEVEL_L1, 0, 0));        // zero count: silent
      send_item(mk_request(LEVEL_L1, 4095, 127));   // top line, then exhausted
      send_item(mk_request(LEVEL_L1, 1, 127));      // saturates to 64, whole color
      send_item(mk_request(LEVEL_L1, 1, 1));        // color full: exhausts at once
      send_item(mk_return(65));                     // free one line in that color
      send_item(mk_request(LEVEL_L1, 1, 2));        // gets 65 back, then exhausted
      send_item(mk_return(100));                    // already free, stays free
      send_item(mk_return(4095));
      send_item(mk_request(LEVEL_L1, 4095, MAX_COUNT));
      send_item(mk_request(LEVEL_L1, 2, MAX_COUNT));
      send_item(mk_return(0));
      send_item(mk_return(0));                      // double return
      send_item(mk_request(LEVEL_L1, 0, 2));
      drain(DRAIN_LIMIT);

      // zero L1 stride acts as 1; L2 stride as wide as the map
      set_regs(0, 4096, 1'b1);
      send_item(mk_request(LEVEL_L2, 7, 3));        // one line per color
      send_item(mk_request(LEVEL_L2, 7, 1));
      send_item(mk_request(LEVEL_L1, 4090, 10));    // walks into an allocated tail
      drain(DRAIN_LIMIT);
      write_reg(CSR_L2_SETS, CSR_DATA_W'(8191));    // all ones
      csr_bus.valid <= 1'b0;
      send_item(mk_request(LEVEL_L2, 9, 2));
      drain(DRAIN_LIMIT);

      // random traffic under a range of settings, extremes included
      set_regs(8191, 1, 1'b1);
      run_random(PHASE_ITEMS, 1'b0);
      drain(DRAIN_LIMIT);
      set_regs($urandom_range(2, 256), $urandom_range(16, 4096), 1'b0);
      run_random(PHASE_ITEMS, 1'b0);
      drain(DRAIN_LIMIT);
      set_regs(32, 512, 1'b1);
      run_random(PHASE_ITEMS, 1'b1);                // back-to-back under output hold
      drain(DRAIN_LIMIT);
      set_regs(4096, 0, 1'b1);
      run_random(PHASE_ITEMS, 1'b0);
      drain(DRAIN_LIMIT);
      set_regs($urandom_range(1, 4096), $urandom_range(1, 4096), 1'($urandom));
      run_random(PHASE_ITEMS, 1'b0);
      drain(DRAIN_LIMIT);
      sb.flush_missing();

      $display("Covered %0d requests (%0d lines granted, %0d exhausted, %0d unsupported),",
               sb.requests, sb.grants, sb.exhausted, sb.unsupported);
      $display("%0d returns, %0d register writes; %0d results checked, %0d mismatches.",
               sb.returns, sb.writes, sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("** set_colored_line_allocator_core: PASSED **");
      else
         $display("** set_colored_line_allocator_core: FAILED **");
      $finish;
   end

endmodule
